[src/jog_pkg.sv]
`timescale 1ns / 1ps

package jog_pkg;

    // Default number of fraction bits of the fixed-point positions.
    localparam int FRAC_BITS_DEF = 16;

    localparam int RES_W      = 17;
    localparam int SKEW_W     = 24;
    localparam int INV_W      = 3;
    localparam int POS_W      = 32;
    localparam int LIM_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [RES_W-1:0] RES_RESET = 17'd655;
    localparam int SKEW_SCALE = 100;

    // Shared multiplier and iterative divide / square-root unit.
    localparam int MUL_W      = 34;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int IT_NW      = 66;
    localparam int DEN_W      = 36;
    localparam int REM_W      = 38;
    localparam int STEP_CNT_W = 7;
    localparam logic [STEP_CNT_W-1:0] DIV_STEPS  = STEP_CNT_W'(IT_NW);
    localparam logic [STEP_CNT_W-1:0] SQRT_STEPS = STEP_CNT_W'(IT_NW / 2);

    // Internal datapath widths.
    localparam int NORM_W = 34;
    localparam int NXT_W  = 34;
    localparam int AX_W   = 48;

    typedef enum logic [1:0] {
        ST_FINISHED = 2'd0,
        ST_MOVING   = 2'd1,
        ST_ERROR    = 2'd2
    } status_t;

    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RES_X   = 3'd0,
        CFG_RES_Y   = 3'd1,
        CFG_RES_Z   = 3'd2,
        CFG_SKEW    = 3'd3,
        CFG_DIR_INV = 3'd4
    } cfg_idx_t;

    typedef enum logic {
        IT_DIV  = 1'b0,
        IT_SQRT = 1'b1
    } it_mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_MUL,
        S_SQ_ACC,
        S_RT_GO,
        S_RT_WAIT,
        S_NX_MUL,
        S_NX_GO,
        S_NX_WAIT,
        S_SK_MUL,
        S_SK_GO,
        S_SK_WAIT,
        S_ST_GO,
        S_ST_WAIT,
        S_APPLY,
        S_ARRIVE,
        S_OUT
    } jog_state_t;

    typedef struct packed {
        logic                    operation;
        logic signed [POS_W-1:0] target_x;
        logic signed [POS_W-1:0] target_y;
        logic signed [POS_W-1:0] target_z;
        logic [LIM_W-1:0]        limit_switches;
        logic                    emergency_stop;
    } jog_in_t;

    typedef struct packed {
        logic                    step_x;
        logic                    dir_x;
        logic                    step_y;
        logic                    dir_y;
        logic                    step_z;
        logic                    dir_z;
        logic [1:0]              move_status;
        logic                    motors_on;
        logic signed [POS_W-1:0] cur_x;
        logic signed [POS_W-1:0] cur_y;
        logic signed [POS_W-1:0] cur_z;
    } jog_out_t;

endpackage

[src/jog_mul.sv]
`timescale 1ns / 1ps

module jog_mul (
    input  logic                       aclk,
    input  logic [jog_pkg::MUL_W-1:0]  a,
    input  logic [jog_pkg::MUL_W-1:0]  b,
    output logic [jog_pkg::PROD_W-1:0] prod
);
    import jog_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    // Unsigned product, registered before anything else uses it.
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

[src/jog_iter.sv]
`timescale 1ns / 1ps

module jog_iter (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  jog_pkg::it_mode_t         mode,
    input  logic [jog_pkg::IT_NW-1:0] num,
    input  logic [jog_pkg::DEN_W-1:0] den,
    output logic                      busy,
    output logic                      done,
    output logic [jog_pkg::IT_NW-1:0] quot
);
    import jog_pkg::*;

    localparam int TW = REM_W + 1;

    logic [IT_NW-1:0]      sh_reg;
    logic [IT_NW-1:0]      q_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [DEN_W:0]        den_reg;
    it_mode_t              mode_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic                  done_reg;

    logic [TW-1:0]    rem_sh;
    logic [TW-1:0]    trial;
    logic [TW:0]      diff;
    logic             ge;
    logic [REM_W-1:0] rem_next;

    // One restoring step per cycle. A divide brings in one numerator bit and
    // tries the doubled divisor; a square root brings in two radicand bits and
    // tries four times the root plus one. Both share the same subtractor.
    always_comb begin
        if (mode_reg == IT_DIV) begin
            rem_sh = {rem_reg, sh_reg[IT_NW-1]};
            trial  = TW'(den_reg);
        end else begin
            rem_sh = {rem_reg[REM_W-2:0], sh_reg[IT_NW-1 -: 2]};
            trial  = {q_reg[TW-3:0], 2'b01};
        end
        diff     = {1'b0, rem_sh} - {1'b0, trial};
        ge       = ~diff[TW];
        rem_next = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= (mode == IT_DIV) ? DIV_STEPS : SQRT_STEPS;
            end else if (cnt_reg != '0) begin
                cnt_reg  <= cnt_reg - STEP_CNT_W'(1);
                done_reg <= (cnt_reg == STEP_CNT_W'(1));
            end
        end
    end

    // The divide works on 2n + d over 2d, which rounds half away from zero.
    always_ff @(posedge aclk) begin
        if (start) begin
            mode_reg <= mode;
            rem_reg  <= '0;
            q_reg    <= '0;
            den_reg  <= {den, 1'b0};
            if (mode == IT_DIV) begin
                sh_reg <= {num[IT_NW-2:0], 1'b0} + IT_NW'(den);
            end else begin
                sh_reg <= num;
            end
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[IT_NW-2:0], ge};
            if (mode_reg == IT_DIV) begin
                sh_reg <= {sh_reg[IT_NW-2:0], 1'b0};
            end else begin
                sh_reg <= {sh_reg[IT_NW-3:0], 2'b00};
            end
        end
    end

    assign busy = (cnt_reg != '0);
    assign done = done_reg;
    assign quot = q_reg;

endmodule

[src/three_axis_linear_jog_stepper.sv]
`timescale 1ns / 1ps

// Three-axis linear jog stepper. A start item loads a target point, sets the
// move to moving and turns the motors on; each tick item advances the position
// by the smallest axis resolution along the straight line to the target,
// derives the per-axis step counts (X with a Y-to-X skew correction), and
// reports step pulses, direction levels, move status and the new position.
// Positions are signed fixed point with FRAC_BITS fraction bits. One result
// item comes back for every input item. A start item, or a tick while the move
// is not running, goes straight to the output state. A tick during a move uses
// one 34-bit multiplier and one shared iterative unit that does a 66-step
// divide or a 33-step square root; besides the square root it needs seven
// divides (three along the path, one for the skew, three for the step counts).
// The block takes no new item while a tick is being worked on, but a finished
// result may wait in the output register while the next item is accepted.
// Configuration writes are always accepted and must only be made while the
// block is idle.
module three_axis_linear_jog_stepper #(
    parameter int FRAC_BITS = jog_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  jog_pkg::jog_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output jog_pkg::jog_out_t              m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [jog_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jog_pkg::CFG_DATA_W-1:0] cfg_data
);
    import jog_pkg::*;

    // Divisor of the skew term: 100 percent in fixed point.
    localparam logic [DEN_W-1:0] SKEW_DEN = DEN_W'(SKEW_SCALE) << FRAC_BITS;

    // Configuration registers.
    logic [RES_W-1:0]         res_reg [3];
    logic signed [SKEW_W-1:0] skew_reg;
    logic [INV_W-1:0]         inv_reg;

    // Architectural state.
    logic signed [POS_W-1:0] pos_reg  [3];
    logic signed [POS_W-1:0] cnt_reg  [3];
    logic signed [POS_W-1:0] goal_reg [3];
    status_t                 status_reg;
    logic                    motor_reg;

    // Per-tick working registers.
    logic [LIM_W-1:0]        lim_reg;
    logic                    estop_reg;
    logic [1:0]              idx_reg;
    logic [IT_NW-1:0]        sum_reg;
    logic [NORM_W-1:0]       norm_reg;
    logic signed [NXT_W-1:0] nxt_reg   [3];
    logic signed [AX_W-1:0]  ax0_reg;
    logic signed [AX_W-1:0]  nstep_reg [3];
    logic [2:0]              dpos_reg;
    logic [2:0]              step_reg;

    jog_out_t   out_reg;
    logic       m_valid_reg;
    jog_state_t state_reg, state_next;

    // Shared unit hookup.
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod;
    logic              it_start;
    it_mode_t          it_mode;
    logic [IT_NW-1:0]  it_num;
    logic [DEN_W-1:0]  it_den;
    logic              it_busy, it_done;
    logic [IT_NW-1:0]  quot;

    // Combinational helpers.
    logic [RES_W-1:0]        res_min;
    logic signed [POS_W:0]   d     [3];
    logic [POS_W:0]          d_mag [3];
    logic [NXT_W-1:0]        nxt1_mag;
    logic [SKEW_W-1:0]       skew_mag;
    logic signed [AX_W-1:0]  axis     [3];
    logic [AX_W-1:0]         axis_mag [3];
    logic signed [NXT_W-1:0] nx_q, nx_val;
    logic signed [AX_W-1:0]  sk_q, ax0_val;
    logic signed [AX_W-1:0]  st_q, ns_val;
    logic                    sk_neg;
    logic                    rt_small;
    logic signed [AX_W-1:0]  delta [3];
    logic [2:0]              big, held, move, dir_up;
    logic                    jump, any_move, err, arrived;
    logic                    s_fire, idx_last;

    jog_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    jog_iter u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (it_start),
        .mode    (it_mode),
        .num     (it_num),
        .den     (it_den),
        .busy    (it_busy),
        .done    (it_done),
        .quot    (quot)
    );

    assign s_fire   = s_valid & s_ready;
    assign idx_last = (idx_reg == 2'd2);

    // Vector to the goal, magnitudes and the rounded quotient terms.
    always_comb begin
        res_min = res_reg[0];
        if (res_reg[1] < res_min) begin
            res_min = res_reg[1];
        end
        if (res_reg[2] < res_min) begin
            res_min = res_reg[2];
        end

        for (int i = 0; i < 3; i++) begin
            d[i]     = {goal_reg[i][POS_W-1], goal_reg[i]} - {pos_reg[i][POS_W-1], pos_reg[i]};
            d_mag[i] = d[i][POS_W] ? -d[i] : d[i];
        end

        nxt1_mag = nxt_reg[1][NXT_W-1] ? -nxt_reg[1] : nxt_reg[1];
        skew_mag = skew_reg[SKEW_W-1] ? -skew_reg : skew_reg;

        axis[0] = ax0_reg;
        axis[1] = AX_W'(nxt_reg[1]);
        axis[2] = AX_W'(nxt_reg[2]);
        for (int i = 0; i < 3; i++) begin
            axis_mag[i] = axis[i][AX_W-1] ? -axis[i] : axis[i];
        end

        // The path step is bounded by the smallest resolution, so the low
        // quotient bits are the whole answer.
        nx_q    = quot[NXT_W-1:0];
        nx_val  = NXT_W'(pos_reg[idx_reg]) + (d[idx_reg][POS_W] ? -nx_q : nx_q);
        sk_neg  = nxt_reg[1][NXT_W-1] ^ skew_reg[SKEW_W-1];
        sk_q    = quot[AX_W-1:0];
        ax0_val = AX_W'(nxt_reg[0]) + (sk_neg ? -sk_q : sk_q);
        st_q    = quot[AX_W-1:0];
        ns_val  = axis[idx_reg][AX_W-1] ? -st_q : st_q;

        rt_small = quot[NORM_W-1:0] < NORM_W'(res_min);
    end

    // Step-count jumps, limit holds and arrival.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            delta[i]  = nstep_reg[i] - AX_W'(cnt_reg[i]);
            big[i]    = !((delta[i] == '0) || (delta[i] == AX_W'(1)) || (delta[i] == '1));
            dir_up[i] = !delta[i][AX_W-1] && (delta[i] != '0);
            held[i]   = (lim_reg[2*i] && delta[i][AX_W-1]) || (lim_reg[2*i+1] && dir_up[i]);
        end
        jump = |big;
        for (int i = 0; i < 3; i++) begin
            move[i] = !jump && !held[i] && (delta[i] != '0);
        end
        any_move = |move;
        err      = jump || (|held) || (any_move && estop_reg);
        arrived  = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (d_mag[i] >= (POS_W+1)'(res_reg[i])) begin
                arrived = 1'b0;
            end
        end
    end

    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_data.operation == OP_TICK && status_reg == ST_MOVING) begin
                        state_next = S_SQ_MUL;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_SQ_MUL:  state_next = S_SQ_ACC;
            S_SQ_ACC:  state_next = idx_last ? S_RT_GO : S_SQ_MUL;
            S_RT_GO:   state_next = S_RT_WAIT;
            S_RT_WAIT: begin
                if (it_done) begin
                    state_next = rt_small ? S_OUT : S_NX_MUL;
                end
            end
            S_NX_MUL:  state_next = S_NX_GO;
            S_NX_GO:   state_next = S_NX_WAIT;
            S_NX_WAIT: begin
                if (it_done) begin
                    state_next = idx_last ? S_SK_MUL : S_NX_MUL;
                end
            end
            S_SK_MUL:  state_next = S_SK_GO;
            S_SK_GO:   state_next = S_SK_WAIT;
            S_SK_WAIT: begin
                if (it_done) begin
                    state_next = S_ST_GO;
                end
            end
            S_ST_GO:   state_next = S_ST_WAIT;
            S_ST_WAIT: begin
                if (it_done) begin
                    state_next = idx_last ? S_APPLY : S_ST_GO;
                end
            end
            S_APPLY:   state_next = S_ARRIVE;
            S_ARRIVE:  state_next = S_OUT;
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Sequencer: operands for the multiplier and the iterative unit.
    always_comb begin
        s_ready  = (state_reg == S_IDLE);
        mul_a    = '0;
        mul_b    = '0;
        it_start = 1'b0;
        it_mode  = IT_DIV;
        it_num   = '0;
        it_den   = '0;
        unique case (state_reg)
            S_SQ_MUL: begin
                mul_a = MUL_W'(d_mag[idx_reg]);
                mul_b = MUL_W'(d_mag[idx_reg]);
            end
            S_RT_GO: begin
                it_start = 1'b1;
                it_mode  = IT_SQRT;
                it_num   = sum_reg;
            end
            S_NX_MUL: begin
                mul_a = MUL_W'(d_mag[idx_reg]);
                mul_b = MUL_W'(res_min);
            end
            S_NX_GO: begin
                it_start = 1'b1;
                it_num   = prod[IT_NW-1:0];
                it_den   = DEN_W'(norm_reg);
            end
            S_SK_MUL: begin
                mul_a = MUL_W'(nxt1_mag);
                mul_b = MUL_W'(skew_mag);
            end
            S_SK_GO: begin
                it_start = 1'b1;
                it_num   = prod[IT_NW-1:0];
                it_den   = SKEW_DEN;
            end
            S_ST_GO: begin
                it_start = 1'b1;
                it_num   = IT_NW'(axis_mag[idx_reg]);
                it_den   = DEN_W'(res_reg[idx_reg]);
            end
            default: begin
            end
        endcase
    end

    assign cfg_ready = 1'b1;

    // Control and architectural state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            status_reg  <= ST_FINISHED;
            motor_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            idx_reg     <= 2'd0;
            skew_reg    <= '0;
            inv_reg     <= '0;
            for (int i = 0; i < 3; i++) begin
                res_reg[i]  <= RES_RESET;
                pos_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
                goal_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_RES_X:   res_reg[0] <= (cfg_data[RES_W-1:0] == '0) ?
                                               RES_W'(1) : cfg_data[RES_W-1:0];
                    CFG_RES_Y:   res_reg[1] <= (cfg_data[RES_W-1:0] == '0) ?
                                               RES_W'(1) : cfg_data[RES_W-1:0];
                    CFG_RES_Z:   res_reg[2] <= (cfg_data[RES_W-1:0] == '0) ?
                                               RES_W'(1) : cfg_data[RES_W-1:0];
                    CFG_SKEW:    skew_reg   <= cfg_data[SKEW_W-1:0];
                    CFG_DIR_INV: inv_reg    <= cfg_data[INV_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (s_fire) begin
                idx_reg <= 2'd0;
                if (s_data.operation == OP_START) begin
                    goal_reg[0] <= s_data.target_x;
                    goal_reg[1] <= s_data.target_y;
                    goal_reg[2] <= s_data.target_z;
                    status_reg  <= ST_MOVING;
                    motor_reg   <= 1'b1;
                end
            end

            if ((state_reg == S_SQ_ACC) ||
                (state_reg == S_NX_WAIT && it_done) ||
                (state_reg == S_ST_WAIT && it_done)) begin
                idx_reg <= idx_last ? 2'd0 : idx_reg + 2'd1;
            end

            // Already within one step of the target: the move simply ends.
            if (state_reg == S_RT_WAIT && it_done && rt_small) begin
                status_reg <= ST_FINISHED;
            end

            if (state_reg == S_APPLY) begin
                if (!jump) begin
                    for (int i = 0; i < 3; i++) begin
                        if (!held[i]) begin
                            cnt_reg[i] <= nstep_reg[i][POS_W-1:0];
                            pos_reg[i] <= nxt_reg[i][POS_W-1:0];
                        end
                    end
                end
                if (err) begin
                    status_reg <= ST_ERROR;
                end
            end

            if (state_reg == S_ARRIVE && arrived) begin
                status_reg <= ST_FINISHED;
                motor_reg  <= 1'b0;
            end

            if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of a tick and the output register.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            lim_reg   <= s_data.limit_switches;
            estop_reg <= s_data.emergency_stop;
            sum_reg   <= '0;
            dpos_reg  <= '0;
            step_reg  <= '0;
        end
        if (state_reg == S_SQ_ACC) begin
            sum_reg <= sum_reg + prod[IT_NW-1:0];
        end
        if (state_reg == S_RT_WAIT && it_done) begin
            norm_reg <= quot[NORM_W-1:0];
        end
        if (state_reg == S_NX_WAIT && it_done) begin
            nxt_reg[idx_reg] <= nx_val;
        end
        if (state_reg == S_SK_WAIT && it_done) begin
            ax0_reg <= ax0_val;
        end
        if (state_reg == S_ST_WAIT && it_done) begin
            nstep_reg[idx_reg] <= ns_val;
        end
        if (state_reg == S_APPLY) begin
            for (int i = 0; i < 3; i++) begin
                dpos_reg[i] <= move[i] && dir_up[i];
                step_reg[i] <= move[i] && !estop_reg;
            end
        end
        if (state_reg == S_OUT && (!m_valid_reg || m_ready)) begin
            out_reg.step_x      <= step_reg[0];
            out_reg.dir_x       <= dpos_reg[0] ^ inv_reg[0];
            out_reg.step_y      <= step_reg[1];
            out_reg.dir_y       <= dpos_reg[1] ^ inv_reg[1];
            out_reg.step_z      <= step_reg[2];
            out_reg.dir_z       <= dpos_reg[2] ^ inv_reg[2];
            out_reg.move_status <= status_reg;
            out_reg.motors_on   <= motor_reg;
            out_reg.cur_x       <= pos_reg[0];
            out_reg.cur_y       <= pos_reg[1];
            out_reg.cur_z       <= pos_reg[2];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // A start item always leaves the move running with the motors on.
    a_start_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_data.operation == OP_START |=> motor_reg && status_reg == ST_MOVING)
        else $error("start item did not enable the move");

    // The shared unit only runs while the sequencer waits for it.
    a_iter_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        it_busy |-> (state_reg == S_RT_WAIT || state_reg == S_NX_WAIT ||
                     state_reg == S_SK_WAIT || state_reg == S_ST_WAIT))
        else $error("iterative unit busy outside a wait state");

    // Motors off means the move is not running.
    a_motor_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.motors_on |-> m_data.move_status != ST_MOVING)
        else $error("result reports a running move with motors off");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import jog_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    jog_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    jog_out_t              m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    three_axis_linear_jog_stepper i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Pending traffic. Register writes are packed as {index, data}.
    jog_in_t                             jog_items[$];
    logic [CFG_IDX_W+CFG_DATA_W-1:0]     reg_writes[$];
    jog_out_t                            expected_moves[$];

    // Idle percentages of the sender and the receiver in the current phase.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    logic        hold_req;
    logic        hold_done;
    int unsigned hold_cnt;
    int unsigned err_cnt;
    int unsigned cycle_cnt;

    // Shadow of the block: its configuration and its motion state.
    int unsigned              axis_res[3];
    longint                   skew_pct;
    logic [2:0]               dir_inv;
    logic signed [POS_W-1:0]  pos_q[3];
    logic signed [POS_W-1:0]  count_q[3];
    logic signed [POS_W-1:0]  goal_q[3];
    status_t                  move_st;
    logic                     motors_q;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Division rounded half away from zero; the divisor is positive.
    function automatic longint div_round(longint n, longint d);
        longint m;
        longint q;
        m = (n < 0) ? -n : n;
        q = (2 * m + d) / (2 * d);
        return (n < 0) ? -q : q;
    endfunction

    // Applies one input item to the shadow state and returns the result item.
    function automatic jog_out_t advance_jog(jog_in_t it);
        jog_out_t    r;
        longint      d[3];
        longint      nxt[3];
        longint      ax[3];
        longint      nstep[3];
        longint      delta[3];
        longint      resmin;
        logic [69:0] sum;
        logic [69:0] cand;
        logic [33:0] mg;
        longint      norm;
        bit          pulse;
        bit          jump;
        bit          complete;
        bit          arrived;
        bit          held;
        pulse = 1'b0;
        for (int i = 0; i < 3; i++) delta[i] = 0;
        if (it.operation == OP_START) begin
            goal_q[0] = it.target_x;
            goal_q[1] = it.target_y;
            goal_q[2] = it.target_z;
            move_st   = ST_MOVING;
            motors_q  = 1'b1;
        end else if (move_st == ST_MOVING) begin
            resmin = axis_res[0];
            if (axis_res[1] < resmin) resmin = axis_res[1];
            if (axis_res[2] < resmin) resmin = axis_res[2];
            sum = '0;
            for (int i = 0; i < 3; i++) begin
                d[i] = longint'(goal_q[i]) - longint'(pos_q[i]);
                mg = (d[i] < 0) ? 34'(-d[i]) : 34'(d[i]);
                sum += 70'(mg) * 70'(mg);
            end
            // Exact integer square root, one bit at a time.
            norm = 0;
            for (int b = 33; b >= 0; b--) begin
                cand = 70'(norm | (64'd1 << b));
                if (cand * cand <= sum) norm = longint'(cand);
            end
            if (norm < resmin) begin
                move_st = ST_FINISHED;
            end else begin
                jump = 1'b0;
                complete = 1'b1;
                for (int i = 0; i < 3; i++)
                    nxt[i] = longint'(pos_q[i]) + div_round(d[i] * resmin, norm);
                ax[0] = nxt[0] + div_round(nxt[1] * skew_pct, longint'(SKEW_SCALE) << 16);
                ax[1] = nxt[1];
                ax[2] = nxt[2];
                for (int i = 0; i < 3; i++) begin
                    nstep[i] = div_round(ax[i], longint'(axis_res[i]));
                    delta[i] = nstep[i] - longint'(count_q[i]);
                    if (delta[i] >= 2 || delta[i] <= -2) jump = 1'b1;
                end
                if (jump) begin
                    for (int i = 0; i < 3; i++) delta[i] = 0;
                    move_st = ST_ERROR;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        held = (it.limit_switches[2*i] && delta[i] < 0) ||
                               (it.limit_switches[2*i+1] && delta[i] > 0);
                        if (held) begin
                            delta[i] = 0;
                            complete = 1'b0;
                        end else begin
                            count_q[i] = nstep[i][31:0];
                            pos_q[i]   = nxt[i][31:0];
                        end
                    end
                    if (delta[0] != 0 || delta[1] != 0 || delta[2] != 0) begin
                        if (it.emergency_stop) complete = 1'b0;
                        else pulse = 1'b1;
                    end
                    if (!complete) move_st = ST_ERROR;
                end
                arrived = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    d[i] = longint'(goal_q[i]) - longint'(pos_q[i]);
                    if (d[i] < 0) d[i] = -d[i];
                    if (d[i] >= longint'(axis_res[i])) arrived = 1'b0;
                end
                if (arrived) begin
                    move_st  = ST_FINISHED;
                    motors_q = 1'b0;
                end
            end
        end
        r.step_x = pulse && delta[0] != 0;
        r.step_y = pulse && delta[1] != 0;
        r.step_z = pulse && delta[2] != 0;
        r.dir_x  = (delta[0] > 0) ^ dir_inv[0];
        r.dir_y  = (delta[1] > 0) ^ dir_inv[1];
        r.dir_z  = (delta[2] > 0) ^ dir_inv[2];
        r.move_status = move_st;
        r.motors_on   = motors_q;
        r.cur_x = pos_q[0];
        r.cur_y = pos_q[1];
        r.cur_z = pos_q[2];
        return r;
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_cnt++;
        end
    endtask

    // Register write channel; the shadow configuration follows each accepted write.
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_RES_X, CFG_RES_Y, CFG_RES_Z: begin
                        axis_res[cfg_index[1:0]] = (cfg_data[16:0] == 0) ? 1 : cfg_data[16:0];
                    end
                    CFG_SKEW:    skew_pct = longint'($signed(cfg_data[23:0]));
                    CFG_DIR_INV: dir_inv = cfg_data[2:0];
                    default: ;
                endcase
            end
            if (!cfg_valid || cfg_ready) begin
                if (reg_writes.size() > 0) begin
                    cfg_valid <= 1'b1;
                    {cfg_index, cfg_data} <= reg_writes.pop_front();
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Item driver: an accepted item is predicted at the edge that takes it,
    // and the next one is offered unless the sender decides to idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) expected_moves.push_back(advance_jog(s_data));
            if (!s_valid || s_ready) begin
                if (jog_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= jog_items.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. A long hold-off lets the block fill up and stall its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_moves.size() == 0) begin
                    $error("result item with no expectation waiting");
                    err_cnt++;
                end else begin
                    jog_out_t e;
                    e = expected_moves.pop_front();
                    check_field("step_x", e.step_x, m_data.step_x);
                    check_field("dir_x", e.dir_x, m_data.dir_x);
                    check_field("step_y", e.step_y, m_data.step_y);
                    check_field("dir_y", e.dir_y, m_data.dir_y);
                    check_field("step_z", e.step_z, m_data.step_z);
                    check_field("dir_z", e.dir_z, m_data.dir_z);
                    check_field("move_status", e.move_status, m_data.move_status);
                    check_field("motors_on", e.motors_on, m_data.motors_on);
                    check_field("cur_x", e.cur_x, m_data.cur_x);
                    check_field("cur_y", e.cur_y, m_data.cur_y);
                    check_field("cur_z", e.cur_z, m_data.cur_z);
                end
            end
            if (hold_req && !hold_done) begin
                hold_cnt  <= 3000;
                hold_done <= 1'b1;
                m_ready   <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                m_ready  <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == 6000000) begin
            $display("three_axis_linear_jog_stepper test failed");
            $finish;
        end
    end

    task automatic add_start(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        jog_in_t it;
        it = '0;
        it.operation = OP_START;
        it.target_x = x;
        it.target_y = y;
        it.target_z = z;
        it.limit_switches = LIM_W'($urandom);
        it.emergency_stop = $urandom_range(0, 1);
        jog_items.push_back(it);
    endtask

    task automatic add_tick(logic [LIM_W-1:0] lim, logic stop);
        jog_in_t it;
        it = jog_in_t'({$urandom, $urandom, $urandom, $urandom});
        it.operation = OP_TICK;
        it.limit_switches = lim;
        it.emergency_stop = stop;
        jog_items.push_back(it);
    endtask

    task automatic add_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        reg_writes.push_back({idx, val});
    endtask

    // Waits until every item has been taken and every result has come back.
    task automatic drain();
        while (jog_items.size() > 0 || s_valid || expected_moves.size() > 0 ||
               reg_writes.size() > 0 || cfg_valid)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Mostly well-formed moves: a start near the origin, then a run of ticks.
    task automatic add_moves(int unsigned n_items);
        int unsigned n;
        int unsigned span;
        int unsigned ticks;
        jog_in_t     it;
        n = 0;
        span = axis_res[0];
        if (axis_res[1] < span) span = axis_res[1];
        if (axis_res[2] < span) span = axis_res[2];
        while (n < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                it = jog_in_t'({$urandom, $urandom, $urandom, $urandom});
                jog_items.push_back(it);
                n++;
            end else begin
                add_start(32'($signed($urandom_range(0, 60)) - 30) * span,
                          32'($signed($urandom_range(0, 60)) - 30) * span,
                          32'($signed($urandom_range(0, 60)) - 30) * span);
                ticks = $urandom_range(1, 50);
                for (int k = 0; k < ticks; k++)
                    add_tick(($urandom_range(0, 9) == 0) ? LIM_W'($urandom) : '0,
                             $urandom_range(0, 19) == 0);
                n += ticks + 1;
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        hold_req  = 1'b0;
        err_cnt   = 0;
        cycle_cnt = 0;
        send_idle_pct = 31;
        recv_idle_pct = 70;
        for (int i = 0; i < 3; i++) begin
            axis_res[i] = RES_RESET;
            pos_q[i] = '0;
            count_q[i] = '0;
            goal_q[i] = '0;
        end
        skew_pct = 0;
        dir_inv  = '0;
        move_st  = ST_FINISHED;
        motors_q = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset configuration.
        add_tick('0, 1'b0);                    // tick with no move running
        add_start(0, 0, 0);
        add_tick('0, 1'b0);                    // already at the target
        add_start(32'sd1965, 0, 0);
        add_tick(6'h02, 1'b0);                 // X max switch holds the axis
        add_tick('0, 1'b0);                    // error stays until a start
        add_start(32'sd1965, -32'sd1310, 32'sd655);
        add_tick('0, 1'b1);                    // emergency stop with a pulse due
        add_start(32'sd1965, -32'sd1310, 32'sd655);
        for (int k = 0; k < 6; k++) add_tick('0, 1'b0);
        add_start(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        add_tick(6'h3f, 1'b1);
        add_tick('0, 1'b0);
        add_start(32'h80000000, 32'h7fffffff, 32'h80000000);
        add_tick('0, 1'b0);
        add_start(0, 0, 0);
        for (int k = 0; k < 3; k++) add_tick('0, 1'b0);
        add_moves(450);
        drain();

        // Coarse X, skew at its positive extreme, every direction inverted.
        add_write(CFG_RES_X, 24'd65536);
        add_write(CFG_RES_Y, 24'd1000);
        add_write(CFG_RES_Z, 24'd300);
        add_write(CFG_SKEW, 24'd6553600);
        add_write(CFG_DIR_INV, 24'd7);
        drain();
        add_start(32'h7fffffff, 32'h80000000, 0);
        add_tick('0, 1'b0);
        add_moves(450);
        drain();

        // Finest resolution, a zero register, skew at its negative extreme.
        send_idle_pct = 70;
        recv_idle_pct = 31;
        add_write(CFG_RES_X, 24'd1);
        add_write(CFG_RES_Y, 24'd65536);
        add_write(CFG_RES_Z, 24'd0);
        add_write(CFG_SKEW, -24'sd6553600);
        add_write(CFG_DIR_INV, 24'd5);
        drain();
        add_moves(450);
        drain();

        // Random settings, no idling, and one long receiver hold-off.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_write(CFG_RES_X, 24'($urandom_range(1, 65536)));
        add_write(CFG_RES_Y, 24'($urandom_range(1, 65536)));
        add_write(CFG_RES_Z, 24'($urandom_range(1, 3000)));
        add_write(CFG_SKEW, 24'($signed($urandom_range(0, 13107200)) - 6553600));
        add_write(CFG_DIR_INV, 24'($urandom_range(0, 7)));
        drain();
        add_moves(450);
        @(posedge aclk);
        hold_req <= 1'b1;
        drain();
        repeat (600) @(posedge aclk);

        if (err_cnt == 0 && expected_moves.size() == 0) begin
            $display("three_axis_linear_jog_stepper test passed");
        end else begin
            $display("three_axis_linear_jog_stepper test failed");
        end
        $finish;
    end

endmodule

[sim.f]
src/jog_pkg.sv
src/jog_mul.sv
src/jog_iter.sv
src/three_axis_linear_jog_stepper.sv
tb/sv/tb.sv
